@@ hw/rtl/auip_pkg.sv @@
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser package
// Shared types, status codes and character constants for the parser.
// ----------------------------------------------------------------------------
package auip_pkg;

  // Parse phase, one-hot encoded.
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_ZERO   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NODIGITS = 2'd2;

  localparam int unsigned BASE_BITS = 6;

  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5a;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_LZ    = 8'h7a;
  localparam logic [7:0] NOT_DIGIT  = 8'hff;

  // Control part of the parse state.
  typedef struct packed {
    phase_e                phase;
    logic                  digit_found;
    logic [BASE_BITS-1:0]  active_base;
    logic [1:0]            error_code;
  } parse_ctrl_t;

  localparam parse_ctrl_t CTRL_RESET = '{
    phase:       PH_SKIP,
    digit_found: 1'b0,
    active_base: BASE_AUTO,
    error_code:  ST_OK
  };

  // Digit value of a character, or NOT_DIGIT for anything else.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = NOT_DIGIT;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      v = c - CHAR_LA + 8'd10;
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      v = c - CHAR_UA + 8'd10;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/auip_step.sv @@
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser step
// Next-state and result logic for one character of the string.
// ----------------------------------------------------------------------------
module auip_step import auip_pkg::*; #(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic [7:0]               char_code_i,
  input  logic                     last_char_i,
  input  logic [BASE_BITS-1:0]     number_base_i,
  input  parse_ctrl_t              ctrl_i,
  input  logic [WORD_BITS-1:0]     acc_i,
  input  logic [POSITION_BITS-1:0] pos_i,
  output parse_ctrl_t              ctrl_o,
  output logic [WORD_BITS-1:0]     acc_o,
  output logic [POSITION_BITS-1:0] pos_o,
  output logic [WORD_BITS-1:0]     parsed_value_o,
  output logic [1:0]               parse_status_o,
  output logic [POSITION_BITS-1:0] stop_position_o
);

  localparam int unsigned PROD_BITS = WORD_BITS + BASE_BITS;

  logic [POSITION_BITS-1:0] pos_inc;
  logic [BASE_BITS-1:0]     cfg_base;
  logic [BASE_BITS-1:0]     take_base;
  logic [BASE_BITS-1:0]     eff_base;
  logic [7:0]               dval;
  logic [PROD_BITS-1:0]     prod;
  logic                     take;
  logic                     is_space;
  parse_ctrl_t              ctrl;
  logic [WORD_BITS-1:0]     acc;
  logic [POSITION_BITS-1:0] pos;
  logic [1:0]               st;

  assign pos_inc  = (&pos_i) ? pos_i : pos_i + 1'b1;
  assign is_space = (char_code_i == CHAR_SPACE) || (char_code_i == CHAR_TAB) ||
                    (char_code_i == CHAR_CR) || (char_code_i == CHAR_LF);
  assign dval     = digit_value(char_code_i);

  always_comb begin
    cfg_base = number_base_i;
    if (cfg_base == BASE_ONE) begin
      cfg_base = BASE_AUTO;
    end
    if (cfg_base > BASE_MAX) begin
      cfg_base = BASE_MAX;
    end
  end

  // One shared multiply-add serves every phase that takes a digit.
  assign eff_base = (take_base < 6'd2) ? BASE_DEC : take_base;
  assign prod     = PROD_BITS'(acc_i) * PROD_BITS'(eff_base) + PROD_BITS'(dval);

  always_comb begin
    ctrl      = ctrl_i;
    acc       = acc_i;
    pos       = pos_i;
    take      = 1'b0;
    take_base = ctrl_i.active_base;
    case (ctrl_i.phase)
      PH_SKIP: begin
        if (is_space) begin
          pos = pos_inc;
        end else if (char_code_i == CHAR_NUL) begin
          ctrl.phase = PH_DONE;
        end else if (char_code_i == CHAR_ZERO) begin
          ctrl.active_base = cfg_base;
          ctrl.digit_found = 1'b1;
          ctrl.phase       = PH_ZERO;
          pos              = pos_inc;
        end else begin
          take_base        = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
          ctrl.active_base = take_base;
          ctrl.phase       = PH_DIGITS;
          take             = 1'b1;
        end
      end
      PH_ZERO: begin
        if (char_code_i == CHAR_LX &&
            (ctrl_i.active_base == BASE_AUTO || ctrl_i.active_base == BASE_HEX)) begin
          ctrl.active_base = BASE_HEX;
          ctrl.digit_found = 1'b0;
          ctrl.phase       = PH_DIGITS;
          pos              = pos_inc;
        end else begin
          if (ctrl_i.active_base == BASE_AUTO) begin
            take_base = (char_code_i inside {[CHAR_ZERO:CHAR_SEVEN]}) ? BASE_OCT : BASE_DEC;
          end
          ctrl.active_base = take_base;
          ctrl.phase       = PH_DIGITS;
          take             = 1'b1;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    if (take) begin
      if (dval >= 8'(eff_base)) begin
        ctrl.phase = PH_DONE;
      end else begin
        ctrl.digit_found = 1'b1;
        if (prod[PROD_BITS-1:WORD_BITS] != '0) begin
          ctrl.error_code = ST_OVERFLOW;
          ctrl.phase      = PH_DONE;
        end else begin
          acc = prod[WORD_BITS-1:0];
          pos = pos_inc;
        end
      end
    end

    st = ctrl.error_code;
    if (st == ST_OK && !ctrl.digit_found) begin
      st = ST_NODIGITS;
    end
    parse_status_o  = st;
    parsed_value_o  = (st == ST_OK) ? acc : '0;
    stop_position_o = (st == ST_OK) ? pos : '0;

    // The end of a string returns the parse state to its reset values.
    if (last_char_i) begin
      ctrl_o = CTRL_RESET;
      acc_o  = '0;
      pos_o  = '0;
    end else begin
      ctrl_o = ctrl;
      acc_o  = acc;
      pos_o  = pos;
    end
  end

endmodule

@@ hw/rtl/ascii_unsigned_integer_parser_top.sv @@
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser
// Parses an unsigned number from characters, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// The input channel carries one character of a string per transfer, with
// in_last_char_i marking the final character. The output channel carries one
// result per string: the parsed value, a status (ok, overflow or no digits)
// and the number of characters consumed. Value and position read zero when
// the status is not ok.
//
// The base is set through the configuration channel, which is always ready.
// A write takes effect for strings whose first non-blank character arrives
// after it.
//
// Each character is first captured in an input register. From there the
// step logic updates the parse state and, for the last character, loads
// the output register, which offers the result. One character is taken
// every cycle unless a final character waits for the output register; the
// single multiply-add by the base sets the cycle's depth.
//
// When the receiver stalls, the result is held in the output register while
// non-final characters keep flowing; a final character waits in the input
// register until the output register is free. Reset clears the parse state,
// both valid flags and selects automatic base detection.
module ascii_unsigned_integer_parser_top import auip_pkg::*; #(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [BASE_BITS-1:0]     cfg_number_base_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               in_char_code_i,
  input  logic                     in_last_char_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [WORD_BITS-1:0]     out_parsed_value_o,
  output logic [1:0]               out_parse_status_o,
  output logic [POSITION_BITS-1:0] out_stop_position_o
);

  logic [BASE_BITS-1:0]     number_base_q;
  logic                     in_valid_q;
  logic [7:0]               char_q;
  logic                     last_q;
  parse_ctrl_t              ctrl_q, ctrl_d;
  logic [WORD_BITS-1:0]     acc_q, acc_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     out_valid_q;
  logic [WORD_BITS-1:0]     value_q, value_d;
  logic [1:0]               status_q, status_d;
  logic [POSITION_BITS-1:0] stop_q, stop_d;
  logic                     advance;

  assign cfg_ready_o = 1'b1;

  // A character leaves the input register unless it would produce a result
  // while the output register still holds one that is not being taken.
  assign advance    = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  auip_step #(
    .WORD_BITS     (WORD_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .char_code_i     (char_q),
    .last_char_i     (last_q),
    .number_base_i   (number_base_q),
    .ctrl_i          (ctrl_q),
    .acc_i           (acc_q),
    .pos_i           (pos_q),
    .ctrl_o          (ctrl_d),
    .acc_o           (acc_d),
    .pos_o           (pos_d),
    .parsed_value_o  (value_d),
    .parse_status_o  (status_d),
    .stop_position_o (stop_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_AUTO;
    end else if (cfg_valid_i) begin
      number_base_q <= cfg_number_base_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= in_char_code_i;
      last_q <= in_last_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= CTRL_RESET;
      acc_q  <= '0;
      pos_q  <= '0;
    end else if (advance) begin
      ctrl_q <= ctrl_d;
      acc_q  <= acc_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      value_q  <= value_d;
      status_q <= status_d;
      stop_q   <= stop_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_parsed_value_o  = value_q;
  assign out_parse_status_o  = status_q;
  assign out_stop_position_o = stop_q;

endmodule

@@ hw/rtl/auip_checker.sv @@
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser checker
// Port-level assertions on the parser's outputs, bound to the top level.
// ----------------------------------------------------------------------------
module auip_checker import auip_pkg::*; #(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [WORD_BITS-1:0]     out_parsed_value_o,
  input logic [1:0]               out_parse_status_o,
  input logic [POSITION_BITS-1:0] out_stop_position_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_parsed_value_o) &&
      $stable(out_parse_status_o) && $stable(out_stop_position_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_parse_status_o == ST_OK || out_parse_status_o == ST_OVERFLOW ||
      out_parse_status_o == ST_NODIGITS))
    else $error("undefined status code");

  // A failed parse reports neither a value nor a position.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_parse_status_o != ST_OK |->
      out_parsed_value_o == '0 && out_stop_position_o == '0)
    else $error("error result carries value or position");

  // An ok result has consumed at least one digit.
  a_ok_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_parse_status_o == ST_OK |-> out_stop_position_o != '0)
    else $error("ok result with zero position");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> cfg_ready_o)
    else $error("configuration channel not ready");

endmodule

bind ascii_unsigned_integer_parser_top auip_checker #(
  .WORD_BITS     (WORD_BITS),
  .POSITION_BITS (POSITION_BITS)
) u_auip_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .cfg_ready_o         (cfg_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .out_parsed_value_o  (out_parsed_value_o),
  .out_parse_status_o  (out_parse_status_o),
  .out_stop_position_o (out_stop_position_o)
);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser testbench
// Streams strings into the parser and checks each result against a typed
// directed row or a cycle-free predictor of the parse, across several bases.
// ----------------------------------------------------------------------------
// The run starts with a short table of directed strings. It covers the
// extreme values, each status code, whitespace skipping, the lowercase-only
// hex prefix, the octal guess in auto mode, bases above 36, base 1, a NUL
// byte and the latching of the base at the first non-blank character. The
// random part follows. It is mostly well-formed numbers in the current base
// with random case, prefixes and trailing junk, and some corrupted strings
// and pure noise. Both channels idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import auip_pkg::*;

  // Number of random characters and the share of them sent without idling.
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned QUIET_FROM   = RANDOM_ITEMS * 4 / 5;
  // Cycles to wait after the last transfer before the block counts as idle.
  // A final character passes the input register and then the result register;
  // the wait leaves a margin over that path.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam longint unsigned WORD_MASK = 64'hFFFF_FFFF;
  localparam int unsigned POS_MAX       = 65535;
  // The directed table cannot hold a NUL byte in a string literal, so this
  // character stands in for NUL there.
  localparam logic [7:0] NUL_MARK       = 8'h7e;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [15:0] pos;
  } parse_result_t;

  // One row of the directed table. When typed is set, res is the result that
  // the string must give. Otherwise the predictor supplies it. When mid is
  // set, the base register is rewritten after the first character.
  typedef struct packed {
    logic [5:0]    base;
    logic          typed;
    parse_result_t res;
    logic          mid;
    logic [5:0]    mid_base;
  } dir_row_t;

  localparam int DIR_ROWS = 15;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{BASE_AUTO, 1'b1, '{32'd0, ST_OK, 16'd1}, 1'b0, BASE_AUTO},
    '{BASE_AUTO, 1'b1, '{32'd0, ST_NODIGITS, 16'd0}, 1'b0, BASE_AUTO},
    '{BASE_AUTO, 1'b0, '0, 1'b0, BASE_AUTO},
    '{BASE_AUTO, 1'b0, '0, 1'b0, BASE_AUTO},
    '{BASE_AUTO, 1'b0, '0, 1'b0, BASE_AUTO},
    '{BASE_AUTO, 1'b1, '{32'd0, ST_NODIGITS, 16'd0}, 1'b0, BASE_AUTO},
    '{BASE_AUTO, 1'b1, '{32'd0, ST_NODIGITS, 16'd0}, 1'b0, BASE_AUTO},
    '{BASE_HEX, 1'b0, '0, 1'b0, BASE_AUTO},
    '{BASE_OCT, 1'b0, '0, 1'b0, BASE_AUTO},
    '{BASE_MAX, 1'b1, '{32'hFFFF_FFFF, ST_OK, 16'd7}, 1'b0, BASE_AUTO},
    '{BASE_MAX, 1'b1, '{32'd0, ST_OVERFLOW, 16'd0}, 1'b0, BASE_AUTO},
    '{BASE_ONE, 1'b0, '0, 1'b0, BASE_AUTO},
    '{6'd63, 1'b0, '0, 1'b0, BASE_AUTO},
    '{BASE_DEC, 1'b1, '{32'd0, ST_NODIGITS, 16'd0}, 1'b0, BASE_AUTO},
    '{BASE_DEC, 1'b0, '0, 1'b1, BASE_HEX}
  };

  string dir_text [DIR_ROWS] = '{
    "0",          // Zero alone.
    "0x",         // A prefix with no digits after it.
    " \t\015\n9", // Every blank character, then a digit.
    "012",        // The octal guess.
    "0X1",        // An uppercase X is no prefix.
    "~5",         // NUL before any digit.
    " ",          // Only whitespace.
    "0xAf",       // A hex prefix in fixed base 16, mixed case.
    "0x5",        // Fixed base 8 makes no guess and takes no prefix.
    "1Z141z3",    // The largest word value in base 36.
    "zzzzzzz",    // Overflow.
    "0x10",       // Base 1 behaves as auto.
    "Z",          // A base above 36 is clamped to 36.
    "\377",       // A byte of 128 or more is never a digit.
    "1f"          // The base changes after the first digit.
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [5:0]  cfg_number_base_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_char_code_i;
  logic        in_last_char_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] out_parsed_value_o;
  logic [1:0]  out_parse_status_o;
  logic [15:0] out_stop_position_o;

  ascii_unsigned_integer_parser_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_number_base_i  (cfg_number_base_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_char_code_i     (in_char_code_i),
    .in_last_char_i     (in_last_char_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_parsed_value_o (out_parsed_value_o),
    .out_parse_status_o (out_parse_status_o),
    .out_stop_position_o(out_stop_position_o)
  );

  // The predictor's copy of the parse state and of the base register.
  phase_e          ph;
  longint unsigned acc;
  bit              got_digit;
  logic [5:0]      cur_base;
  int unsigned     pos;
  logic [1:0]      err;
  logic [5:0]      base_reg;

  // Parsed numbers that the block still owes, oldest first.
  parse_result_t   number_q [$];
  // The string that is about to be sent.
  logic [7:0]      line_q [$];

  bit              quiet;
  int unsigned     error_count;
  int unsigned     stall_cycles;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic void reset_parse();
    ph        = PH_SKIP;
    acc       = 0;
    got_digit = 1'b0;
    cur_base  = BASE_AUTO;
    pos       = 0;
    err       = ST_OK;
  endfunction

  function automatic void bump_pos();
    if (pos < POS_MAX) pos++;
  endfunction

  // Value of a character as a digit, or 255 when it is none. Setting bit 5
  // folds uppercase letters onto lowercase without touching other ranges
  // that could land in a to z.
  function automatic int unsigned char_digit(logic [7:0] c);
    logic [7:0] folded;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
    folded = c | 8'h20;
    if (c >= CHAR_UA && folded >= CHAR_LA && folded <= CHAR_LZ) return folded - CHAR_LA + 10;
    return 255;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    longint unsigned radix;
    longint unsigned d;
    radix = (cur_base < 2) ? 10 : cur_base;
    d = char_digit(c);
    if (d >= radix) begin
      ph = PH_DONE;
      return;
    end
    got_digit = 1'b1;
    if (acc > (WORD_MASK - d) / radix) begin
      err = ST_OVERFLOW;
      ph  = PH_DONE;
      return;
    end
    acc = acc * radix + d;
    bump_pos();
  endfunction

  // Advances the parse by one character. It returns 1, with the number in r,
  // when the character ends the string.
  function automatic bit parse_char(input logic [7:0] c, input bit last,
                                    output parse_result_t r);
    logic [5:0] b;
    logic [1:0] st;
    r = '0;
    case (ph)
      PH_SKIP: begin
        if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
          bump_pos();
        end else if (c == CHAR_NUL) begin
          ph = PH_DONE;
        end else begin
          // The base is latched here, at the first non-blank character.
          b = (base_reg == BASE_ONE) ? BASE_AUTO : base_reg;
          if (b > BASE_MAX) b = BASE_MAX;
          cur_base = b;
          if (c == CHAR_ZERO) begin
            got_digit = 1'b1;
            bump_pos();
            ph = PH_ZERO;
          end else begin
            if (cur_base == BASE_AUTO) cur_base = BASE_DEC;
            ph = PH_DIGITS;
            add_digit(c);
          end
        end
      end
      PH_ZERO: begin
        if (c == CHAR_LX && (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
          // The zero of a prefix is no digit of the number.
          cur_base  = BASE_HEX;
          got_digit = 1'b0;
          bump_pos();
          ph = PH_DIGITS;
        end else begin
          if (cur_base == BASE_AUTO) begin
            cur_base = (c >= CHAR_ZERO && c <= CHAR_SEVEN) ? BASE_OCT : BASE_DEC;
          end
          ph = PH_DIGITS;
          add_digit(c);
        end
      end
      PH_DIGITS: add_digit(c);
      default: ;
    endcase
    if (!last) return 1'b0;
    st = err;
    if (st == ST_OK && !got_digit) st = ST_NODIGITS;
    r.status = st;
    if (st == ST_OK) begin
      r.value = acc[31:0];
      r.pos   = pos[15:0];
    end
    reset_parse();
    return 1'b1;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_CR;
      default: return CHAR_LF;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < 10) return CHAR_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(d - 10);
  endfunction

  // Builds a well-formed number in the base that the register selects, with
  // optional blanks in front and junk behind. Some values sit at the top of
  // the word and some beyond it.
  function automatic void build_number_line(logic [5:0] reg_base);
    int unsigned     radix;
    longint unsigned v;
    logic [7:0]      digs [$];
    line_q.delete();
    repeat ($urandom_range(0, 3)) line_q.push_back(blank_char());
    radix = (reg_base > BASE_MAX) ? 36 : reg_base;
    if (radix < 2) begin
      case ($urandom_range(0, 2))
        0: radix = 10;
        1: begin
          radix = 16;
          line_q.push_back(CHAR_ZERO);
          line_q.push_back(CHAR_LX);
        end
        default: begin
          radix = 8;
          line_q.push_back(CHAR_ZERO);
        end
      endcase
    end else if (radix == 16 && $urandom_range(0, 1) == 1) begin
      line_q.push_back(CHAR_ZERO);
      line_q.push_back(CHAR_LX);
    end
    case ($urandom_range(0, 7))
      0: v = WORD_MASK;
      1: v = WORD_MASK + 1 + longint'($urandom);
      2: v = $urandom_range(0, 99);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (v == 0) digs.push_back(CHAR_ZERO);
    while (v != 0) begin
      digs.push_front(digit_char(int'(v % radix)));
      v = v / radix;
    end
    foreach (digs[k]) line_q.push_back(digs[k]);
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_noise_line();
    line_q.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0: line_q.push_back(blank_char());
        1: line_q.push_back(digit_char($urandom_range(0, 35)));
        default: line_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic logic [5:0] phase_base(int unsigned n);
    case (n)
      0: return BASE_AUTO;
      1: return BASE_DEC;
      2: return BASE_HEX;
      3: return BASE_MAX;
      4: return 6'd2;
      5: return BASE_OCT;
      6: return BASE_ONE;
      7: return 6'd63;
      8: return 6'd37;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag_error($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Sends one character, with an optional idle burst in front of it. Valid
  // stays high across back-to-back characters. The predictor runs once the
  // transfer has happened, so its order matches the block's.
  task automatic push_char(input logic [7:0] c, input bit last, input bit typed,
                           input parse_result_t typed_r);
    parse_result_t r;
    int unsigned   gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_char_code_i <= c;
    in_last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (parse_char(c, last, r)) number_q.push_back(typed ? typed_r : r);
  endtask

  task automatic send_line();
    foreach (line_q[k]) push_char(line_q[k], k == line_q.size() - 1, 1'b0, '0);
  endtask

  // Holds the sender back until every owed number has arrived and the
  // pipeline has had time to empty. The register is only written after this.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (number_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base(logic [5:0] b);
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_number_base_i <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    base_reg = b;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver takes results most of the time and stalls in random bursts,
  // except in the quiet part at the end.
  initial begin
    int unsigned hold;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet || $urandom_range(0, 5) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        hold = $urandom_range(1, 18);
        repeat (hold - 1) @(negedge clk_i);
      end
    end
  end

  // Every result transfer is matched against the oldest owed number.
  always @(posedge clk_i) begin : check_results
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (number_q.size() == 0) begin
        flag_error($sformatf("unexpected result: value 0x%0h, status %0d",
                             out_parsed_value_o, out_parse_status_o));
      end else begin
        want = number_q.pop_front();
        check_field("parsed_value", want.value, out_parsed_value_o);
        check_field("parse_status", 32'(want.status), 32'(out_parse_status_o));
        check_field("stop_position", 32'(want.pos), 32'(out_stop_position_o));
      end
    end
  end

  // The watchdog ends a run in which no transfer of any kind happens for
  // far longer than the worst idle bursts of both sides could explain.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [7:0]  ch;
    int unsigned sent;
    int unsigned chunk;
    int unsigned phase_no;
    int unsigned keep;
    int unsigned kind;

    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_number_base_i = BASE_AUTO;
    in_valid_i        = 1'b0;
    in_char_code_i    = CHAR_NUL;
    in_last_char_i    = 1'b0;
    quiet             = 1'b0;
    error_count       = 0;
    stall_cycles      = 0;
    base_reg          = BASE_AUTO;
    reset_parse();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The base register is only rewritten when a row needs a
    // different one, and always with the block idle.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].base != base_reg) begin
        settle();
        write_base(dir_rows[i].base);
      end
      for (int k = 0; k < dir_text[i].len(); k++) begin
        if (dir_rows[i].mid && k == 1) begin
          // The string has already latched its base, so this write must
          // only affect the strings that follow.
          settle();
          write_base(dir_rows[i].mid_base);
        end
        ch = dir_text[i][k];
        if (ch == NUL_MARK) ch = CHAR_NUL;
        push_char(ch, k == dir_text[i].len() - 1, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random part, in phases of about 120 characters, each with its own base.
    // The settle between phases also makes the sender wait until every owed
    // number has come back.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      write_base(phase_base(phase_no));
      phase_no++;
      chunk = 0;
      while (chunk < 120 && sent < RANDOM_ITEMS) begin
        quiet = (sent >= QUIET_FROM);
        kind  = $urandom_range(0, 19);
        if (kind < 14) begin
          build_number_line(base_reg);
        end else if (kind < 17) begin
          // A well-formed number that is cut short or gets a bad byte.
          build_number_line(base_reg);
          case ($urandom_range(0, 2))
            0: begin
              keep = $urandom_range(1, line_q.size());
              while (line_q.size() > keep) void'(line_q.pop_back());
            end
            1: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            default: line_q.insert($urandom_range(0, line_q.size() - 1), CHAR_NUL);
          endcase
        end else begin
          build_noise_line();
        end
        send_line();
        chunk += line_q.size();
        sent  += line_q.size();
      end
    end

    // Wait for the last results, then keep the clock running to catch any stray
    // transfer.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (number_q.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/auip_pkg.sv
hw/rtl/auip_step.sv
hw/rtl/ascii_unsigned_integer_parser_top.sv
hw/rtl/auip_checker.sv
sim/testbench.sv
